// ===== rtl/core/sism_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sism_pkg
// Shared types and codes for the sorted interval set merge block: channel
// words, controller commands and status, state and action codes.
// ----------------------------------------------------------------------------
package sism_pkg;

	localparam int DIVISOR_BITS = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CELL_SIZE = 1'b1;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_MISS = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [31:0] coordinate;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  found_index;
		logic [31:0] found_start;
		logic [31:0] found_end;
		logic [10:0] segment_count;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_SRD,
		S_SCMP,
		S_SFIN,
		S_DEC1,
		S_NCAP,
		S_DEC2,
		S_SHINIT,
		S_SHIFT,
		S_WRITE,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		ACT_HEAD,
		ACT_EXT_U,
		ACT_KEEP_U,
		ACT_END_U,
		ACT_BRIDGE,
		ACT_LOW_N,
		ACT_NEW_0,
		ACT_NEW_N,
		ACT_LOOK
	} act_t;

	typedef enum logic [1:0] {
		RD_MID,
		RD_BASE,
		RD_NEXT,
		RD_SHIFT
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_TOUCH,
		RES_FULL,
		RES_MISS
	} res_sel_t;

	typedef struct packed {
		logic     load;
		rd_sel_t  rd_sel;
		logic     srch_init;
		logic     srch_step;
		logic     srch_fin;
		logic     n_cap;
		logic     act_go;
		act_t     act;
		logic     sh_init;
		logic     sh_down;
		logic     sh_run;
		logic     wr_t;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     out_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic lookup;
		logic div_done;
		logic cnt_zero;
		logic cnt_full;
		logic n_gt1;
		logic f_neg;
		logic u_last;
		logic s_le_eu;
		logic e_le_eu;
		logic e_ge_su;
		logic e_lt_sn;
		logic sh_done;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/sism_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sism_div
// Restoring divider by a 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sism_div #(
	parameter int W = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [W-1:0]                      dividend,
	input  wire logic [sism_pkg::DIVISOR_BITS-1:0] divisor,
	output logic [W-1:0]                           quotient,
	output logic                                   done
);
	import sism_pkg::*;

	localparam int CBW = $clog2(W + 1);

	logic                    busy_q;
	logic [CBW-1:0]          cnt_q;
	logic [W-1:0]            quo_q;
	logic [DIVISOR_BITS-1:0] rem_q;
	logic [DIVISOR_BITS-1:0] dv_q;
	logic [DIVISOR_BITS:0]   trial;
	logic                    fits;

	assign trial = {rem_q, quo_q[W-1]};
	assign fits = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CBW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CBW'(1);
			if (cnt_q == CBW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIVISOR_BITS'(trial - {1'b0, dv_q});
			end else begin
				rem_q <= DIVISOR_BITS'(trial);
			end
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done = !busy_q;

endmodule
`default_nettype wire

// ===== rtl/core/sism_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sism_dp
// Datapath: interval bounds, two dividers, segment memory, binary search
// registers, shift engine and result register.
// ----------------------------------------------------------------------------
module sism_dp #(
	parameter int MAX_SEGMENTS = 1024,
	parameter int COORD_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sism_pkg::in_word_t                in_data,
	input  wire logic [sism_pkg::DIVISOR_BITS-1:0] half_width,
	input  wire logic [sism_pkg::DIVISOR_BITS-1:0] divisor,
	input  wire sism_pkg::cmd_t                    cmd,
	output sism_pkg::stat_t                        st,
	output sism_pkg::out_word_t                    out_data
);
	import sism_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CNW = $clog2(MAX_SEGMENTS + 1);
	localparam int EW = CW + DIVISOR_BITS + 1;

	// Segment store.
	logic [CW-1:0] st_mem [MAX_SEGMENTS];
	logic [CW-1:0] en_mem [MAX_SEGMENTS];
	logic [CW-1:0] rd_st_q, rd_en_q;
	logic [IW-1:0] raddr, waddr;
	logic          we;
	logic [CW-1:0] wst, wen;

	logic [EW-1:0] x_e, hw_e, mask_e, sum_e;
	logic [CW-1:0] lo_div, hi_div, s_w, e_w;
	logic          lo_done, hi_done;

	logic            lookup_q;
	logic [CNW-1:0]  cnt_q, n_q;
	logic [IW-1:0]   base_q, half;
	logic            f_neg_q;
	logic [CW-1:0]   su_q, eu_q, sn_q, en_q;
	logic [IW-1:0]   t_idx_q;
	logic [CW-1:0]   t_s_q, t_e_q;
	logic [IW-1:0]   sh_rd_q, sh_wa_q;
	logic [CNW-1:0]  sh_left_q;
	logic            sh_pend_q, sh_down_q;
	out_word_t       out_q;

	// Interval bounds before the division, both saturating.
	assign x_e = EW'(CW'(in_data.coordinate));
	assign hw_e = EW'(half_width);
	assign mask_e = EW'({CW{1'b1}});
	assign sum_e = x_e + hw_e;

	always_comb begin
		if (in_data.cmd == CMD_LOOKUP) begin
			lo_div = CW'(x_e);
		end else if (x_e < hw_e) begin
			lo_div = '0;
		end else begin
			lo_div = CW'(x_e - hw_e);
		end
		hi_div = (sum_e > mask_e) ? CW'(mask_e) : CW'(sum_e);
	end

	sism_div #(.W(CW)) u_div_lo (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.load),
		.dividend(lo_div),
		.divisor (divisor),
		.quotient(s_w),
		.done    (lo_done)
	);

	sism_div #(.W(CW)) u_div_hi (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.load),
		.dividend(hi_div),
		.divisor (divisor),
		.quotient(e_w),
		.done    (hi_done)
	);

	assign half = IW'(n_q >> 1);

	always_comb begin
		case (cmd.rd_sel)
			RD_MID:   raddr = base_q + half;
			RD_BASE:  raddr = base_q;
			RD_NEXT:  raddr = base_q + IW'(1);
			RD_SHIFT: raddr = sh_rd_q;
			default:  raddr = base_q;
		endcase
	end

	assign we = cmd.wr_t || (cmd.sh_run && sh_pend_q);
	always_comb begin
		if (cmd.wr_t) begin
			waddr = t_idx_q;
			wst = t_s_q;
			wen = t_e_q;
		end else begin
			waddr = sh_down_q ? sh_wa_q - IW'(1) : sh_wa_q + IW'(1);
			wst = rd_st_q;
			wen = rd_en_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			st_mem[waddr] <= wst;
			en_mem[waddr] <= wen;
		end
		rd_st_q <= st_mem[raddr];
		rd_en_q <= en_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sh_left_q <= '0;
			sh_pend_q <= 1'b0;
			sh_down_q <= 1'b0;
			lookup_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				lookup_q <= in_data.cmd;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNW'(1);
			end
			if (cmd.sh_init) begin
				sh_down_q <= cmd.sh_down;
				sh_pend_q <= 1'b0;
				if (cmd.sh_down) begin
					sh_left_q <= cnt_q - CNW'(t_idx_q) - CNW'(2);
				end else begin
					sh_left_q <= cnt_q - CNW'(t_idx_q);
				end
			end else if (cmd.sh_run) begin
				if (sh_left_q != '0) begin
					sh_pend_q <= 1'b1;
					sh_left_q <= sh_left_q - CNW'(1);
				end else begin
					sh_pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			base_q <= '0;
			n_q <= cnt_q;
		end else if (cmd.srch_step) begin
			if (rd_st_q <= s_w) begin
				base_q <= base_q + half;
			end
			n_q <= n_q - CNW'(half);
		end
		if (cmd.srch_fin) begin
			f_neg_q <= s_w < rd_st_q;
			su_q <= rd_st_q;
			eu_q <= rd_en_q;
		end
		if (cmd.n_cap) begin
			sn_q <= rd_st_q;
			en_q <= rd_en_q;
		end
		if (cmd.sh_init) begin
			sh_rd_q <= cmd.sh_down ? t_idx_q + IW'(2) : IW'(cnt_q - CNW'(1));
		end else if (cmd.sh_run && sh_left_q != '0) begin
			sh_wa_q <= sh_rd_q;
			sh_rd_q <= sh_down_q ? sh_rd_q + IW'(1) : sh_rd_q - IW'(1);
		end
		if (cmd.act_go) begin
			case (cmd.act)
				ACT_HEAD: begin
					t_idx_q <= '0;
					t_s_q <= s_w;
					t_e_q <= (eu_q < e_w) ? e_w : eu_q;
				end
				ACT_EXT_U: begin
					t_idx_q <= base_q;
					t_s_q <= su_q;
					t_e_q <= (eu_q < e_w) ? e_w : eu_q;
				end
				ACT_KEEP_U, ACT_LOOK: begin
					t_idx_q <= base_q;
					t_s_q <= su_q;
					t_e_q <= eu_q;
				end
				ACT_END_U: begin
					t_idx_q <= base_q;
					t_s_q <= su_q;
					t_e_q <= e_w;
				end
				ACT_BRIDGE: begin
					t_idx_q <= base_q;
					t_s_q <= su_q;
					t_e_q <= en_q;
				end
				ACT_LOW_N: begin
					t_idx_q <= base_q + IW'(1);
					t_s_q <= s_w;
					t_e_q <= (en_q < e_w) ? e_w : en_q;
				end
				ACT_NEW_N: begin
					t_idx_q <= base_q + IW'(1);
					t_s_q <= s_w;
					t_e_q <= e_w;
				end
				default: begin
					t_idx_q <= '0;
					t_s_q <= s_w;
					t_e_q <= e_w;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_q.segment_count <= 11'(cnt_q);
			case (cmd.res_sel)
				RES_TOUCH: begin
					out_q.status <= STAT_DONE;
					out_q.found_index <= 10'(t_idx_q);
					out_q.found_start <= 32'(t_s_q);
					out_q.found_end <= 32'(t_e_q);
				end
				RES_FULL: begin
					out_q.status <= STAT_FULL;
					out_q.found_index <= '0;
					out_q.found_start <= 32'(s_w);
					out_q.found_end <= 32'(e_w);
				end
				default: begin
					out_q.status <= STAT_MISS;
					out_q.found_index <= '0;
					out_q.found_start <= '0;
					out_q.found_end <= '0;
				end
			endcase
		end
	end

	always_comb begin
		st.lookup = lookup_q;
		st.div_done = lo_done && hi_done;
		st.cnt_zero = cnt_q == '0;
		st.cnt_full = cnt_q == CNW'(MAX_SEGMENTS);
		st.n_gt1 = n_q > CNW'(1);
		st.f_neg = f_neg_q;
		st.u_last = (CNW'(base_q) + CNW'(1)) == cnt_q;
		st.s_le_eu = s_w <= eu_q;
		st.e_le_eu = e_w <= eu_q;
		st.e_ge_su = e_w >= su_q;
		st.e_lt_sn = e_w < sn_q;
		st.sh_done = (sh_left_q == '0) && !sh_pend_q;
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/sism_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sism_ctrl
// Controller: sequences division, binary search, insert decision, shifting
// and write-back, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module sism_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire sism_pkg::stat_t st,
	output sism_pkg::cmd_t       cmd
);
	import sism_pkg::*;

	state_t   state_q, state_d;
	act_t     act_q, act_d;
	res_sel_t res_q, res_d;
	logic     out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_NEW_0;
			res_q <= RES_MISS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			act_q <= act_d;
			res_q <= res_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		act_d = act_q;
		res_d = res_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (st.div_done) begin
					if (!st.cnt_zero) begin
						cmd.srch_init = 1'b1;
						state_d = S_SRD;
					end else if (st.lookup) begin
						res_d = RES_MISS;
						state_d = S_OUT;
					end else begin
						cmd.act_go = 1'b1;
						cmd.act = ACT_NEW_0;
					end
				end
			end
			S_SRD: begin
				if (st.n_gt1) begin
					cmd.rd_sel = RD_MID;
					state_d = S_SCMP;
				end else begin
					cmd.rd_sel = RD_BASE;
					state_d = S_SFIN;
				end
			end
			S_SCMP: begin
				cmd.srch_step = 1'b1;
				state_d = S_SRD;
			end
			S_SFIN: begin
				cmd.srch_fin = 1'b1;
				state_d = S_DEC1;
			end
			S_DEC1: begin
				if (st.lookup) begin
					if (st.f_neg) begin
						res_d = RES_MISS;
						state_d = S_OUT;
					end else begin
						cmd.act_go = 1'b1;
						cmd.act = ACT_LOOK;
					end
				end else if (st.f_neg) begin
					cmd.act_go = 1'b1;
					cmd.act = st.e_ge_su ? ACT_HEAD : ACT_NEW_0;
				end else if (st.u_last) begin
					cmd.act_go = 1'b1;
					cmd.act = st.s_le_eu ? ACT_EXT_U : ACT_NEW_N;
				end else begin
					// The right neighbour is needed to decide.
					cmd.rd_sel = RD_NEXT;
					state_d = S_NCAP;
				end
			end
			S_NCAP: begin
				cmd.n_cap = 1'b1;
				state_d = S_DEC2;
			end
			S_DEC2: begin
				cmd.act_go = 1'b1;
				if (st.s_le_eu) begin
					if (st.e_le_eu) begin
						cmd.act = ACT_KEEP_U;
					end else if (st.e_lt_sn) begin
						cmd.act = ACT_END_U;
					end else begin
						cmd.act = ACT_BRIDGE;
					end
				end else begin
					cmd.act = st.e_lt_sn ? ACT_NEW_N : ACT_LOW_N;
				end
			end
			S_SHINIT: begin
				cmd.sh_init = 1'b1;
				cmd.sh_down = act_q == ACT_BRIDGE;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.sh_run = 1'b1;
				cmd.rd_sel = RD_SHIFT;
				if (st.sh_done) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.wr_t = 1'b1;
				cmd.cnt_inc = act_q inside {ACT_NEW_0, ACT_NEW_N};
				cmd.cnt_dec = act_q == ACT_BRIDGE;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					cmd.res_sel = res_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cmd.act_go) begin
			act_d = cmd.act;
			res_d = RES_TOUCH;
			if (cmd.act == ACT_LOOK) begin
				state_d = S_OUT;
			end else if (cmd.act inside {ACT_NEW_0, ACT_NEW_N}) begin
				if (st.cnt_full) begin
					res_d = RES_FULL;
					state_d = S_OUT;
				end else begin
					state_d = S_SHINIT;
				end
			end else if (cmd.act == ACT_BRIDGE) begin
				state_d = S_SHINIT;
			end else begin
				state_d = S_WRITE;
			end
		end
	end

	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/sorted_interval_set_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_interval_set_merge
// Sorted store of disjoint cell-index intervals with add and lookup words.
// ----------------------------------------------------------------------------
// Usage: the input channel carries a command and a coordinate; the output
// channel returns one result word per input word, in order. Both use
// valid/stall, and a word moves on an edge with valid high and stall low.
// Configuration (half_width, cell_size) is written through cfg_we; the user
// must write it only while idle, which the block does not enforce. One word
// is worked on at a time; in_stall is high from acceptance until its result
// is placed in the output register. Work on a word runs through division, a
// binary search over the stored segments, the decision, a shift of every
// segment that an insert or a removal moves in the memory, which has one
// read and one write port, write-back for an add and loading of the result.
// A finished result may wait in the output register while the next word is
// accepted; the block holds a further result until the receiver drops stall.
// Reset empties the store at once (a count register); no clearing pass runs.
// ----------------------------------------------------------------------------
module sorted_interval_set_merge #(
	parameter int MAX_SEGMENTS = 1024,
	parameter int COORD_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire sism_pkg::in_word_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output sism_pkg::out_word_t                     out_data,
	input  wire logic                               cfg_we,
	input  wire logic [sism_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [sism_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import sism_pkg::*;

	logic [DIVISOR_BITS-1:0] half_width_q, cell_size_q, divisor;
	cmd_t  cmd;
	stat_t st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= '0;
			cell_size_q <= DIVISOR_BITS'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_HALF_WIDTH) begin
				half_width_q <= cfg_data;
			end else if (cfg_index == REG_CELL_SIZE) begin
				cell_size_q <= cfg_data;
			end
		end
	end

	// A zero cell size behaves as one.
	assign divisor = (cell_size_q == '0) ? DIVISOR_BITS'(1) : cell_size_q;

	sism_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.st       (st),
		.cmd      (cmd)
	);

	sism_dp #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.half_width(half_width_q),
		.divisor   (divisor),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== rtl/core/sism_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sism_chk
// Port-level checks for the sorted interval set merge block, bound to it.
// ----------------------------------------------------------------------------
module sism_chk #(
	parameter int MAX_SEGMENTS = 1024
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire sism_pkg::out_word_t out_data
);
	import sism_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while one is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STAT_DONE || out_data.status == STAT_FULL ||
			out_data.status == STAT_MISS))
		else $error("undefined status code");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_MISS |->
			out_data.found_index == '0 && out_data.found_start == '0 &&
			out_data.found_end == '0)
		else $error("missed lookup carries segment data");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_FULL |->
			out_data.segment_count == 11'(MAX_SEGMENTS))
		else $error("store full reported below capacity");

endmodule

bind sorted_interval_set_merge sism_chk #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_sism_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
`default_nettype wire
